### hdl/deq_pkg.sv
// Shared types and constants for the double-ended queue with search.
package deq_pkg;

  localparam int ACTION_W = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_POP_FRONT  = 3'd1,
    ACT_PUSH_BACK  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_SEARCH     = 3'd4
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SEARCH
  } state_t;

  typedef struct packed {
    logic push_front;
    logic pop_front;
    logic push_back;
    logic pop_back;
  } ptr_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ptr_stat_t;

endpackage

### hdl/deq_ram.sv
// Entry store: one write port, one read port with registered read data.
module deq_ram #(
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [deq_pkg::DATA_W-1:0]                 wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [deq_pkg::DATA_W-1:0]                 rdata
);
  import deq_pkg::*;

  logic [DATA_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### hdl/deq_ptr.sv
// Front index and entry count, with the slot arithmetic of the circular store.
module deq_ptr #(
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  deq_pkg::ptr_cmd_t                            cmd,
  output deq_pkg::ptr_stat_t                           stat,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] front,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] front_inc,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] front_dec,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] back_slot,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] last_slot,
  output logic [$clog2(DEPTH+1)-1:0]                   count
);
  import deq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [AW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] sum_back, sum_last;

  assign front     = front_r;
  assign count     = count_r;
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);

  assign front_inc = (front_r == AW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;

  assign sum_back  = SW'(front_r) + SW'(count_r);
  assign sum_last  = sum_back - 1'b1;
  assign back_slot = (sum_back >= SW'(DEPTH)) ? AW'(sum_back - SW'(DEPTH)) : AW'(sum_back);
  assign last_slot = (sum_last >= SW'(DEPTH)) ? AW'(sum_last - SW'(DEPTH)) : AW'(sum_last);

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    if (cmd.push_front) begin
      front_nxt = front_dec;
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop_front) begin
      front_nxt = front_inc;
      count_nxt = count_r - 1'b1;
    end else if (cmd.push_back) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop_back) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_front_range: assert property (@(posedge clk) disable iff (!rst_n)
    SW'(front_r) < SW'(DEPTH))
    else $error("front index out of range");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    stat.full && (cmd.push_front || cmd.push_back) |-> 1'b0)
    else $error("push while full");

endmodule

### hdl/deque_with_search.sv
// Top level: request sequencer, pointer unit and entry store of the deque.
//
//  channel  ports                                   handshake
//  -------  --------------------------------------  ----------------------------
//  in       in_action, in_value                     start && !busy
//  out      out_popped_value, out_position,         out_valid, one-cycle strobe
//           out_status
//
// Push, refused push, empty pop or search, unused action: result registered, issued in the cycle after the request.
// Pop: the entry passes through the registered memory read port, then the result register.
// Search: one stored entry read and compared per cycle, from the front, until a match or the last live entry.
// Synchronous active-low reset empties the store; no clearing pass.
// Results cannot be stalled; busy stays high until an item's result is issued.
module deque_with_search #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [deq_pkg::ACTION_W-1:0]        in_action,
  input  logic signed [deq_pkg::DATA_W-1:0]   in_value,
  output logic                                out_valid,
  output logic signed [deq_pkg::DATA_W-1:0]   out_popped_value,
  output logic [deq_pkg::POS_W-1:0]           out_position,
  output logic [deq_pkg::STATUS_W-1:0]        out_status
);
  import deq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  state_t            state_r, state_nxt;
  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] popped_r, popped_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [AW-1:0]     scan_r, scan_nxt;
  logic [CW-1:0]     cmp_r, cmp_nxt;

  ptr_cmd_t          cmd;
  ptr_stat_t         stat;
  logic [AW-1:0]     front, front_inc, front_dec, back_slot, last_slot;
  logic [CW-1:0]     count;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] rdata;
  logic              accept;

  deq_ptr #(.DEPTH(DEPTH)) u_ptr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .front     (front),
    .front_inc (front_inc),
    .front_dec (front_dec),
    .back_slot (back_slot),
    .last_slot (last_slot),
    .count     (count)
  );

  deq_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt  = state_r;
    valid_nxt  = 1'b0;
    popped_nxt = '0;
    pos_nxt    = '0;
    status_nxt = STS_OK;
    key_nxt    = key_r;
    scan_nxt   = scan_r;
    cmp_nxt    = cmp_r;
    cmd        = '0;
    we         = 1'b0;
    waddr      = front_dec;
    raddr      = front;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_PUSH_FRONT: begin
              valid_nxt = 1'b1;
              if (stat.full) begin
                status_nxt = STS_FULL;
              end else begin
                we             = 1'b1;
                waddr          = front_dec;
                cmd.push_front = 1'b1;
              end
            end
            ACT_PUSH_BACK: begin
              valid_nxt = 1'b1;
              if (stat.full) begin
                status_nxt = STS_FULL;
              end else begin
                we            = 1'b1;
                waddr         = back_slot;
                cmd.push_back = 1'b1;
              end
            end
            ACT_POP_FRONT: begin
              if (stat.empty) begin
                valid_nxt  = 1'b1;
                status_nxt = STS_EMPTY;
              end else begin
                raddr         = front;
                cmd.pop_front = 1'b1;
                state_nxt     = ST_POP;
              end
            end
            ACT_POP_BACK: begin
              if (stat.empty) begin
                valid_nxt  = 1'b1;
                status_nxt = STS_EMPTY;
              end else begin
                raddr        = last_slot;
                cmd.pop_back = 1'b1;
                state_nxt    = ST_POP;
              end
            end
            ACT_SEARCH: begin
              if (stat.empty) begin
                valid_nxt  = 1'b1;
                status_nxt = STS_EMPTY;
              end else begin
                raddr     = front;
                key_nxt   = in_value;
                scan_nxt  = front_inc;
                cmp_nxt   = CW'(1);
                state_nxt = ST_SEARCH;
              end
            end
            default: begin
              valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        valid_nxt  = 1'b1;
        popped_nxt = rdata;
        state_nxt  = ST_IDLE;
      end
      ST_SEARCH: begin
        raddr    = scan_r;
        scan_nxt = (scan_r == AW'(DEPTH - 1)) ? '0 : scan_r + 1'b1;
        if (rdata == key_r) begin
          valid_nxt = 1'b1;
          pos_nxt   = POS_W'(cmp_r);
          state_nxt = ST_IDLE;
        end else if (cmp_r == count) begin
          valid_nxt  = 1'b1;
          status_nxt = STS_NOT_FOUND;
          state_nxt  = ST_IDLE;
        end else begin
          cmp_nxt = cmp_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    popped_r <= popped_nxt;
    pos_r    <= pos_nxt;
    status_r <= status_nxt;
    key_r    <= key_nxt;
    scan_r   <= scan_nxt;
    cmp_r    <= cmp_nxt;
  end

  assign out_valid        = valid_r;
  assign out_popped_value = popped_r;
  assign out_position     = pos_r;
  assign out_status       = status_r;

  a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POP |=> valid_r && state_r == ST_IDLE)
    else $error("pop did not finish in one cycle");

  a_search_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEARCH |-> !valid_r)
    else $error("result issued during search");

  a_search_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEARCH |-> cmp_r != '0 && cmp_r <= count)
    else $error("search position outside live entries");

endmodule
